// ===== rtl/core/mhpq_pkg.sv =====
// package for the min-heap priority queue: widths, record type, codes
// no dependencies
`timescale 1ns / 1ps
package mhpq_pkg;
  localparam int Capacity = 128;
  localparam int AddrW = $clog2(Capacity + 1);
  localparam int CountW = $clog2(Capacity + 1);

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] arr;
    logic signed [31:0] svc;
    logic signed [31:0] dep;
  } rec_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_INIT, S_DN_RDL, S_DN_RDR, S_DN_CMP,
    S_TOP_RD, S_TOP_WAIT, S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic ins_start;
    logic pop_start;
    logic up_rd;
    logic up_move;
    logic up_place;
    logic dn_init;
    logic dn_rd_l;
    logic dn_rd_r;
    logic dn_move;
    logic dn_place;
    logic top_rd;
    logic top_cap;
    logic set_empty;
    logic set_full;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_pop;
    logic empty;
    logic full;
    logic up_more;
    logic up_less;
    logic dn_has_l;
    logic dn_has_r;
    logic dn_less;
    logic cnt_zero;
  } sts_t;
endpackage

// ===== rtl/core/mhpq_if.sv =====
// valid/ready channel interface carrying one payload type
// no dependencies
`timescale 1ns / 1ps
interface mhpq_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/min_heap_priority_queue.sv =====
// top level of the min-heap priority queue
// depends on mhpq_pkg, mhpq_ctrl, mhpq_dpath
//
// Usage: in channel carries one operation (insert record or pop minimum);
// out channel returns one result per operation with status, popped record,
// count and the new minimum. One item is worked at a time: in_ready is high
// only while the controller is idle.
// An insert reads one parent record per level moved up and stops at the
// root or when a compare stops it; a pop reads both children per level
// moved down and stops at a leaf or when a compare stops it. Pop on empty
// and insert on full skip the sift. Every item then reads the new root and
// holds the block until its result is taken and the controller is idle.
// Reset (rst_n low, synchronous) empties the heap; store contents are not
// cleared, entries beyond the count never reach the outputs.
// When the receiver stalls the result is held in its register and no new
// item is accepted until it is taken.
`timescale 1ns / 1ps
module min_heap_priority_queue (
  input logic clk,
  input logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic in_action,
  input  logic signed [31:0] in_key_time,
  input  logic signed [31:0] in_arrival_time,
  input  logic signed [31:0] in_service_start,
  input  logic signed [31:0] in_departure_time,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_status,
  output logic signed [31:0] out_popped_key,
  output logic signed [31:0] out_popped_arrival,
  output logic signed [31:0] out_popped_service,
  output logic signed [31:0] out_popped_departure,
  output logic [7:0] out_entry_count,
  output logic signed [31:0] out_top_key,
  output logic signed [31:0] out_top_arrival,
  output logic signed [31:0] out_top_departure
);
  import mhpq_pkg::*;
  cmd_t cmd;
  sts_t sts;
  rec_t in_rec, popped, top;
  status_t st;

  assign in_rec = '{key: in_key_time, arr: in_arrival_time,
                    svc: in_service_start, dep: in_departure_time};

  // sequencing
  mhpq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  // storage and compare
  mhpq_dpath u_dpath (
    .clk(clk), .rst_n(rst_n), .in_action(in_action), .in_rec(in_rec),
    .cmd(cmd), .sts(sts), .res_status(st), .res_popped(popped),
    .res_count(out_entry_count), .res_top(top)
  );

  assign out_status = st;
  assign out_popped_key = popped.key;
  assign out_popped_arrival = popped.arr;
  assign out_popped_service = popped.svc;
  assign out_popped_departure = popped.dep;
  assign out_top_key = top.key;
  assign out_top_arrival = top.arr;
  assign out_top_departure = top.dep;
endmodule

// ===== rtl/core/mhpq_ctrl.sv =====
// controller state machine for heap insert and pop sequencing
// depends on mhpq_pkg
`timescale 1ns / 1ps
module mhpq_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  mhpq_pkg::sts_t sts,
  output mhpq_pkg::cmd_t cmd
);
  import mhpq_pkg::*;
  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_DN_INIT;
        end
      end
      S_DN_INIT: begin
        if (!sts.is_pop) begin
          if (sts.full) begin
            cmd.set_full = 1'b1;
            state_nxt = S_TOP_RD;
          end else begin
            cmd.ins_start = 1'b1;
            state_nxt = S_UP_RD;
          end
        end else if (sts.empty) begin
          cmd.set_empty = 1'b1;
          state_nxt = S_TOP_RD;
        end else begin
          cmd.pop_start = 1'b1;
          state_nxt = S_DN_RDL;
        end
      end
      S_UP_RD: begin
        if (sts.up_more) begin
          cmd.up_rd = 1'b1;
          state_nxt = S_UP_CMP;
        end else begin
          cmd.up_place = 1'b1;
          state_nxt = S_TOP_RD;
        end
      end
      S_UP_CMP: begin
        if (sts.up_less) begin
          cmd.up_move = 1'b1;
          state_nxt = S_UP_RD;
        end else begin
          cmd.up_place = 1'b1;
          state_nxt = S_TOP_RD;
        end
      end
      S_DN_RDL: begin
        if (sts.cnt_zero) begin
          state_nxt = S_TOP_RD;
        end else if (sts.dn_has_l) begin
          cmd.dn_rd_l = 1'b1;
          state_nxt = S_DN_RDR;
        end else begin
          cmd.dn_place = 1'b1;
          state_nxt = S_TOP_RD;
        end
      end
      S_DN_RDR: begin
        cmd.dn_rd_r = 1'b1;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts.dn_less) begin
          cmd.dn_move = 1'b1;
          state_nxt = S_DN_RDL;
        end else begin
          cmd.dn_place = 1'b1;
          state_nxt = S_TOP_RD;
        end
      end
      S_TOP_RD: begin
        cmd.top_rd = 1'b1;
        state_nxt = S_TOP_WAIT;
      end
      S_TOP_WAIT: begin
        cmd.top_cap = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // only one sift command per cycle
  a_one_move: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.up_move, cmd.dn_move, cmd.up_place, cmd.dn_place}))
    else $error("conflicting store writes");
  // a result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  // no new item while a result is offered
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("accept during result");
endmodule

// ===== rtl/core/mhpq_dpath.sv =====
// datapath: record store, count, sift pointers and result register
// depends on mhpq_pkg
`timescale 1ns / 1ps
module mhpq_dpath (
  input  logic clk,
  input  logic rst_n,
  input  logic in_action,
  input  mhpq_pkg::rec_t in_rec,
  input  mhpq_pkg::cmd_t cmd,
  output mhpq_pkg::sts_t sts,
  output mhpq_pkg::status_t res_status,
  output mhpq_pkg::rec_t res_popped,
  output logic [7:0] res_count,
  output mhpq_pkg::rec_t res_top
);
  import mhpq_pkg::*;

  rec_t mem [1:Capacity];
  rec_t rd_r;
  rec_t cur_r;
  rec_t left_r;
  rec_t popped_r;
  rec_t top_r;
  logic act_r;
  status_t status_r;
  logic [CountW-1:0] cnt_r;
  logic [AddrW-1:0] pos_r;
  logic [AddrW:0] lch;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic wr_en, rd_en;
  rec_t wr_data;
  logic right_sel;
  rec_t child;
  logic pop_d_r;
  logic root_rd;
  rec_t root_q;

  assign lch = {pos_r, 1'b0};
  assign right_sel = (lch != (AddrW+1)'(cnt_r)) && (rd_r.key < left_r.key);
  assign child = right_sel ? rd_r : left_r;

  // status to controller
  always_comb begin
    sts.is_pop = act_r;
    sts.empty = (cnt_r == '0);
    sts.full = (cnt_r >= CountW'(Capacity));
    sts.up_more = (pos_r > AddrW'(1));
    sts.up_less = cur_r.key < rd_r.key;
    sts.dn_has_l = (lch <= (AddrW+1)'(cnt_r));
    sts.dn_has_r = (lch < (AddrW+1)'(cnt_r));
    sts.dn_less = child.key < cur_r.key;
    sts.cnt_zero = (cnt_r == '0);
  end

  // store address and write selection
  always_comb begin
    rd_en = 1'b0;
    rd_addr = pos_r;
    wr_en = 1'b0;
    wr_addr = pos_r;
    wr_data = cur_r;
    if (cmd.pop_start) begin
      rd_en = 1'b1;
      rd_addr = AddrW'(cnt_r);
    end
    if (cmd.up_rd) begin
      rd_en = 1'b1;
      rd_addr = pos_r >> 1;
    end
    if (cmd.dn_rd_l) begin
      rd_en = 1'b1;
      rd_addr = lch[AddrW-1:0];
    end
    if (cmd.dn_rd_r) begin
      rd_en = sts.dn_has_r;
      rd_addr = lch[AddrW-1:0] + AddrW'(1);
    end
    if (cmd.top_rd) begin
      rd_en = 1'b1;
      rd_addr = AddrW'(1);
    end
    if (cmd.up_move) begin
      wr_en = 1'b1;
      wr_data = rd_r;
    end
    if (cmd.dn_move) begin
      wr_en = 1'b1;
      wr_data = child;
    end
    // first sift cycle: the last record is still in the read register
    if (cmd.dn_place && pop_d_r) wr_data = rd_r;
    if (cmd.up_place || cmd.dn_place) wr_en = 1'b1;
  end

  // record store
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_r <= mem[rd_addr];
  end

  // count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.ins_start) begin
      cnt_r <= cnt_r + CountW'(1);
    end else if (cmd.pop_start) begin
      cnt_r <= cnt_r - CountW'(1);
    end
  end

  // sift pointers and records, first pop cycle takes root and last record
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r <= in_action;
      cur_r <= in_rec;
      status_r <= ST_DONE;
      popped_r <= '0;
    end
    if (pop_d_r) begin
      popped_r <= root_q;
      cur_r <= rd_r;
    end
    if (cmd.set_empty) status_r <= ST_EMPTY;
    if (cmd.set_full) status_r <= ST_FULL;
    if (cmd.ins_start) pos_r <= AddrW'(cnt_r) + AddrW'(1);
    if (cmd.pop_start) pos_r <= AddrW'(1);
    if (cmd.up_move) pos_r <= pos_r >> 1;
    if (cmd.dn_rd_l) begin
      // latch left child after its read completes next cycle
    end
    if (cmd.dn_rd_r) left_r <= rd_r;
    if (cmd.dn_move) pos_r <= right_sel ? lch[AddrW-1:0] + AddrW'(1) : lch[AddrW-1:0];
    if (cmd.top_cap) top_r <= rd_r;
  end

  // first pop cycle marker
  always_ff @(posedge clk) begin
    if (!rst_n) pop_d_r <= 1'b0;
    else pop_d_r <= cmd.pop_start;
  end

  // root read at pop start
  assign root_rd = cmd.pop_start;
  always_ff @(posedge clk) begin
    if (root_rd) root_q <= mem[1];
  end

  assign res_status = status_r;
  assign res_popped = popped_r;
  assign res_count = 8'(cnt_r);
  assign res_top = (cnt_r == '0) ? '0 : top_r;
endmodule

// ===== tb/min_heap_priority_queue_test.sv =====
// testbench for min_heap_priority_queue: directed and random insert/pop traffic
// depends on mhpq_pkg, mhpq_if and the min_heap_priority_queue rtl
`timescale 1ns / 1ps
module min_heap_priority_queue_test;
  import mhpq_pkg::*;

  typedef enum logic {OP_INSERT = 1'b0, OP_POP = 1'b1} op_kind_t;

  typedef struct packed {
    op_kind_t action;
    rec_t     rec;
  } heap_op_t;

  typedef struct packed {
    status_t            status;
    rec_t               popped;
    logic [7:0]         entry_count;
    logic signed [31:0] top_key;
    logic signed [31:0] top_arrival;
    logic signed [31:0] top_departure;
  } heap_res_t;

  localparam logic signed [31:0] MinusOne = 32'shFFFF0000;
  localparam int CycleLimit = 600000;

  logic clk;
  logic rst_n;

  mhpq_if #(.payload_t(heap_op_t)) in_ch (clk);
  mhpq_if #(.payload_t(heap_res_t)) out_ch (clk);

  min_heap_priority_queue u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_ch.valid),
    .in_ready            (in_ch.ready),
    .in_action           (in_ch.data.action),
    .in_key_time         (in_ch.data.rec.key),
    .in_arrival_time     (in_ch.data.rec.arr),
    .in_service_start    (in_ch.data.rec.svc),
    .in_departure_time   (in_ch.data.rec.dep),
    .out_valid           (out_ch.valid),
    .out_ready           (out_ch.ready),
    .out_status          (out_ch.data.status),
    .out_popped_key      (out_ch.data.popped.key),
    .out_popped_arrival  (out_ch.data.popped.arr),
    .out_popped_service  (out_ch.data.popped.svc),
    .out_popped_departure(out_ch.data.popped.dep),
    .out_entry_count     (out_ch.data.entry_count),
    .out_top_key         (out_ch.data.top_key),
    .out_top_arrival     (out_ch.data.top_arrival),
    .out_top_departure   (out_ch.data.top_departure)
  );

  // heap mirror, slots 1..held_count are live
  rec_t      heap_mirror [1:Capacity];
  int        held_count;
  heap_res_t expected_results [$];
  int        error_count;
  int        cycle_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // work out the result of one operation and update the mirror
  function automatic void predict_heap_op(input heap_op_t op);
    heap_res_t res;
    rec_t      moving;
    int        pos;
    int        child;
    res = '0;
    res.status = ST_DONE;
    if (op.action == OP_INSERT) begin
      if (held_count >= Capacity) begin
        res.status = ST_FULL;
      end else begin
        held_count++;
        pos = held_count;
        while (pos > 1 && op.rec.key < heap_mirror[pos / 2].key) begin
          heap_mirror[pos] = heap_mirror[pos / 2];
          pos = pos / 2;
        end
        heap_mirror[pos] = op.rec;
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.popped = heap_mirror[1];
      heap_mirror[1] = heap_mirror[held_count];
      held_count--;
      if (held_count > 0) begin
        moving = heap_mirror[1];
        pos = 1;
        while (pos * 2 <= held_count) begin
          child = pos * 2;
          if (child != held_count && heap_mirror[child + 1].key < heap_mirror[child].key)
            child++;
          if (!(heap_mirror[child].key < moving.key)) break;
          heap_mirror[pos] = heap_mirror[child];
          pos = child;
        end
        heap_mirror[pos] = moving;
      end
    end
    res.entry_count = held_count[7:0];
    if (held_count > 0) begin
      res.top_key = heap_mirror[1].key;
      res.top_arrival = heap_mirror[1].arr;
      res.top_departure = heap_mirror[1].dep;
    end
    expected_results.push_back(res);
  endfunction

  // one transfer on the input channel; valid stays high for back-to-back items
  task automatic send_op(input op_kind_t action, input rec_t rec);
    heap_op_t op;
    op.action = action;
    op.rec = rec;
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= op;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_heap_op(op);
  endtask

  task automatic end_of_burst();
    in_ch.valid <= 1'b0;
    in_ch.data.action <= op_kind_t'($urandom_range(1));
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_time();
    case ($urandom_range(5))
      0: rand_time = MinusOne;
      1: rand_time = $urandom_range(7);
      2: rand_time = 32'sh80000000 + $urandom_range(3);
      3: rand_time = 32'sh7FFFFFFF - $urandom_range(3);
      default: rand_time = $urandom;
    endcase
  endfunction

  function automatic rec_t rand_rec();
    rec_t r;
    r.key = rand_time();
    r.arr = $urandom;
    r.svc = ($urandom_range(3) == 0) ? MinusOne : $urandom;
    r.dep = ($urandom_range(3) == 0) ? MinusOne : $urandom;
    return r;
  endfunction

  function automatic rec_t make_rec(input logic signed [31:0] k);
    rec_t r;
    r.key = k;
    r.arr = $urandom;
    r.svc = $urandom;
    r.dep = $urandom;
    return r;
  endfunction

  // result checker and receiver stalls
  always @(posedge clk) begin
    heap_res_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t result with nothing expected", $realtime);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.data.status !== want.status)
            report_mismatch("status", 32'(out_ch.data.status), 32'(want.status));
          if (out_ch.data.popped.key !== want.popped.key)
            report_mismatch("popped_key", out_ch.data.popped.key, want.popped.key);
          if (out_ch.data.popped.arr !== want.popped.arr)
            report_mismatch("popped_arrival", out_ch.data.popped.arr, want.popped.arr);
          if (out_ch.data.popped.svc !== want.popped.svc)
            report_mismatch("popped_service", out_ch.data.popped.svc, want.popped.svc);
          if (out_ch.data.popped.dep !== want.popped.dep)
            report_mismatch("popped_departure", out_ch.data.popped.dep, want.popped.dep);
          if (out_ch.data.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(out_ch.data.entry_count),
                            32'(want.entry_count));
          if (out_ch.data.top_key !== want.top_key)
            report_mismatch("top_key", out_ch.data.top_key, want.top_key);
          if (out_ch.data.top_arrival !== want.top_arrival)
            report_mismatch("top_arrival", out_ch.data.top_arrival, want.top_arrival);
          if (out_ch.data.top_departure !== want.top_departure)
            report_mismatch("top_departure", out_ch.data.top_departure, want.top_departure);
        end
      end
    end
  end

  // pop on empty, extreme keys, ties, unset payloads, drain
  task automatic test_directed();
    rec_t r;
    send_op(OP_POP, '1);
    send_op(OP_INSERT, make_rec(32'sh7FFFFFFF));
    send_op(OP_INSERT, make_rec(32'sh80000000));
    send_op(OP_INSERT, make_rec(32'sh00000000));
    send_op(OP_INSERT, make_rec(MinusOne));
    r.key = 32'sh00010000;
    r.arr = 32'sh00000000;
    r.svc = MinusOne;
    r.dep = MinusOne;
    send_op(OP_INSERT, r);
    r.arr = 32'shFFFFFFFF;
    r.svc = 32'sh7FFFFFFF;
    r.dep = 32'sh80000000;
    send_op(OP_INSERT, r);
    send_op(OP_INSERT, make_rec(32'sh00010000));
    send_op(OP_POP, rand_rec());
    send_op(OP_POP, '0);
    repeat (5) send_op(OP_POP, rand_rec());
    send_op(OP_POP, rand_rec());
    end_of_burst();
  endtask

  // fill to capacity, insert on full, then empty again
  task automatic test_full_heap();
    while (held_count < Capacity) send_op(OP_INSERT, make_rec($urandom_range(40) - 20));
    send_op(OP_INSERT, rand_rec());
    send_op(OP_INSERT, rand_rec());
    while (held_count > 0) send_op(OP_POP, rand_rec());
    send_op(OP_POP, rand_rec());
    end_of_burst();
  endtask

  // random traffic steered toward a drifting fill level
  task automatic test_random_traffic(input int n_ops);
    int fill_target;
    fill_target = $urandom_range(Capacity);
    for (int i = 0; i < n_ops; i++) begin
      if (i % 60 == 0) begin
        case ($urandom_range(3))
          0: fill_target = 0;
          1: fill_target = Capacity;
          default: fill_target = $urandom_range(Capacity);
        endcase
      end
      if ((held_count < fill_target) == ($urandom_range(99) < 80))
        send_op(OP_INSERT, rand_rec());
      else
        send_op(OP_POP, rand_rec());
      if ($urandom_range(49) == 0) end_of_burst();
    end
    end_of_burst();
  endtask

  task automatic wait_for_results();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    held_count = 0;
    send_idle_pct = 31;
    recv_idle_pct = 75;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_heap();
    test_random_traffic(300);
    send_idle_pct = 75;
    recv_idle_pct = 31;
    test_random_traffic(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_full_heap();
    test_random_traffic(150);
    wait_for_results();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== min_heap_priority_queue.f =====
rtl/core/mhpq_pkg.sv
rtl/core/mhpq_if.sv
rtl/core/mhpq_ctrl.sv
rtl/core/mhpq_dpath.sv
rtl/core/min_heap_priority_queue.sv
tb/min_heap_priority_queue_test.sv
